[rtl/core/mwa_pkg.sv]
// ----------------------------------------------------------------------------
// mwa_pkg
// Shared types and constants for the max window average block.
// ----------------------------------------------------------------------------
package mwa_pkg;

   // defaults for the top-level parameters
   localparam int WINDOW_MAX_DEF   = 256;
   localparam int SAMPLE_WIDTH_DEF = 16;

   // result format: signed, 8 fraction bits
   localparam int OUT_W    = 24;
   localparam int FRAC_W   = 8;
   localparam logic [OUT_W-1:0] OUT_MOST_NEG = {1'b1, {(OUT_W-1){1'b0}}};

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int WLEN_W     = 9;
   localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(1);
   localparam logic [CSR_ADDR_W-3:0] REG_WINDOW_LEN = '0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_START,
      ST_DIVIDE,
      ST_FINISH
   } mwa_state_type;

   typedef struct packed {
      logic accept;     // capture sample, read oldest ring entry
      logic update;     // fold sample into window sum and best sum
      logic div_start;  // launch the average division
      logic load_out;   // load result register and restart the sequence
   } mwa_cmd_type;

   typedef struct packed {
      logic last;       // held transaction marks end of sequence
      logic full_seen;  // a full window exists in this sequence
      logic div_done;   // divider finishes on this edge
   } mwa_status_type;

endpackage

[rtl/core/mwa_div.sv]
// ----------------------------------------------------------------------------
// mwa_div
// Restoring divider, one quotient bit per cycle, unsigned magnitude.
// ----------------------------------------------------------------------------
module mwa_div import mwa_pkg::*; #(
   parameter int N_W = 33,
   parameter int D_W = 9
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           done,
   output logic [N_W-1:0] quotient,
   output logic           rem_nonzero
);

   localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [N_W-1:0]   shreg_ff, shreg_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W:0]     rem_shift;
   logic             q_bit;

   assign done        = busy_ff && (cnt_ff == CNT_W'(N_W - 1));
   assign quotient    = shreg_ff;
   assign rem_nonzero = (rem_ff != '0);

   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      shreg_in  = shreg_ff;
      rem_in    = rem_ff;
      rem_shift = {rem_ff, shreg_ff[N_W-1]};
      q_bit     = (rem_shift >= {1'b0, divisor});
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shreg_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         // dividend bits shift out the top, quotient bits shift in the bottom
         shreg_in = {shreg_ff[N_W-2:0], q_bit};
         rem_in   = q_bit ? D_W'(rem_shift - {1'b0, divisor}) : D_W'(rem_shift);
         cnt_in   = cnt_ff + CNT_W'(1);
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
   end

endmodule

[rtl/core/mwa_datapath.sv]
// ----------------------------------------------------------------------------
// mwa_datapath
// Sample ring, running and best window sums, divider and result register.
// ----------------------------------------------------------------------------
module mwa_datapath import mwa_pkg::*; #(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mwa_cmd_type                    cmd,
   output mwa_status_type                 status,
   input  logic                           cfg_restart,
   input  logic [$clog2(WINDOW_MAX+1)-1:0] win_len,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_end_of_sequence,
   output logic signed [OUT_W-1:0]        rsp_max_average,
   output logic                           rsp_window_found
);

   localparam int K_W   = $clog2(WINDOW_MAX + 1);
   localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int AW    = K_W + 1;
   localparam int SUM_W = SAMPLE_WIDTH + $clog2(WINDOW_MAX) + 1;
   localparam int N_W   = SUM_W + FRAC_W;

   logic [SAMPLE_WIDTH-1:0] ring [WINDOW_MAX];

   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] old_ff;
   logic                           last_ff;
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic signed [SUM_W-1:0]        best_ff;
   logic [K_W-1:0]                 fill_ff, fill_in;
   logic [PTR_W-1:0]               wp_ff, wp_in;
   logic signed [OUT_W-1:0]        avg_ff;
   logic                           found_ff;

   logic [AW-1:0]          addr_diff;
   logic [AW-1:0]          addr_wrap;
   logic [PTR_W-1:0]       rd_addr;
   logic                   full_now;
   logic                   full_after;
   logic                   restart;
   logic signed [N_W-1:0]  dividend;
   logic [N_W-1:0]         magnitude;
   logic                   div_done;
   logic [N_W-1:0]         quotient;
   logic                   rem_nonzero;
   logic                   neg_ff;
   logic signed [N_W-1:0]  result;

   assign restart  = cmd.load_out || cfg_restart;
   assign full_now = (fill_ff == win_len);

   // oldest sample in the window sits win_len entries behind the write pointer
   assign addr_diff = AW'(wp_ff) - AW'(win_len);
   assign addr_wrap = addr_diff[AW-1] ? (addr_diff + AW'(WINDOW_MAX)) : addr_diff;
   assign rd_addr   = addr_wrap[PTR_W-1:0];

   always_comb begin
      sum_in     = sum_ff + SUM_W'(sample_ff);
      fill_in    = fill_ff;
      if (full_now) begin
         sum_in = sum_in - SUM_W'(old_ff);
      end else begin
         fill_in = fill_ff + K_W'(1);
      end
      full_after = (fill_in == win_len);
      wp_in      = (wp_ff == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_ff + PTR_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         old_ff <= ring[rd_addr];
      end
      if (cmd.update) begin
         ring[wp_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         fill_ff <= '0;
         wp_ff   <= '0;
      end else if (restart) begin
         sum_ff  <= '0;
         fill_ff <= '0;
         wp_ff   <= '0;
      end else if (cmd.update) begin
         sum_ff  <= sum_in;
         fill_ff <= fill_in;
         wp_ff   <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
         last_ff   <= req_end_of_sequence;
      end
      // first full window always seeds the best sum
      if (cmd.update && full_after && (!full_now || (sum_in > best_ff))) begin
         best_ff <= sum_in;
      end
   end

   // floor division: |n| / k, then fold the sign back with a floor correction
   assign dividend  = {best_ff, {FRAC_W{1'b0}}};
   assign magnitude = best_ff[SUM_W-1] ? N_W'(-dividend) : N_W'(dividend);

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= best_ff[SUM_W-1];
      end
   end

   mwa_div #(
      .N_W (N_W),
      .D_W (K_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .dividend    (magnitude),
      .divisor     (win_len),
      .done        (div_done),
      .quotient    (quotient),
      .rem_nonzero (rem_nonzero)
   );

   always_comb begin
      if (!neg_ff) begin
         result = quotient;
      end else if (rem_nonzero) begin
         result = ~quotient;
      end else begin
         result = -quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         found_ff <= full_now;
         avg_ff   <= full_now ? OUT_W'(result) : OUT_MOST_NEG;
      end
   end

   assign status.last      = last_ff;
   assign status.full_seen = full_now;
   assign status.div_done  = div_done;

   assign rsp_max_average  = avg_ff;
   assign rsp_window_found = found_ff;

endmodule

[rtl/core/mwa_ctrl.sv]
// ----------------------------------------------------------------------------
// mwa_ctrl
// Sequencer for sample intake, end-of-sequence division and result handoff.
// ----------------------------------------------------------------------------
module mwa_ctrl import mwa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output mwa_cmd_type    cmd,
   input  mwa_status_type status
);

   mwa_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.last ? ST_START : ST_IDLE;
         end
         ST_START: begin
            if (status.full_seen) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the result register to drain
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/max_window_average.sv]
// ----------------------------------------------------------------------------
// max_window_average
// Largest fixed-length window average over a stream of signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample per transaction; req_end_of_sequence marks the
//   final sample of a sequence. Each accepted sample first reads the oldest
//   ring entry and then updates the window sums; req_stall stays high until
//   both are done, so a new sample is not taken before the last is through.
//   On the final sample one rsp_* transaction follows: the best window sum
//   times 256 divided by the window length, floored, plus rsp_window_found
//   (0 when the sequence was shorter than the window). The divider yields one
//   quotient bit per cycle, N = SAMPLE_WIDTH + log2(WINDOW_MAX) + 9 bits. The
//   result is registered once any division is done and the result register
//   is free. The sequence state then restarts.
//   The result register lets the next sample in while a result is stalled;
//   a second result waits in the sequencer until rsp_stall drops.
//   Register window_len (byte address 0) sets the window, 0 acts as 1 and
//   values above WINDOW_MAX saturate; writing it restarts the sequence and
//   must happen while the block is idle. Reset sets window_len to 1 and
//   clears the sequence state; the sample ring needs no clearing.
// ----------------------------------------------------------------------------
module max_window_average import mwa_pkg::*; #(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_end_of_sequence,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [OUT_W-1:0]        rsp_max_average,
   output logic                           rsp_window_found,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [CSR_ADDR_W-1:0]          paddr,
   input  logic [CSR_DATA_W-1:0]          pwdata,
   output logic [CSR_DATA_W-1:0]          prdata,
   output logic                           pready
);

   localparam int K_W = $clog2(WINDOW_MAX + 1);

   logic [WLEN_W-1:0] window_len_ff;
   logic              csr_hit;
   logic              csr_write;
   logic [K_W-1:0]    win_len;

   mwa_cmd_type    cmd;
   mwa_status_type status;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1:2] == REG_WINDOW_LEN);
   assign csr_write = psel && penable && pwrite && csr_hit;
   assign prdata    = csr_hit ? CSR_DATA_W'(window_len_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WLEN_RESET;
      end else if (csr_write) begin
         window_len_ff <= pwdata[WLEN_W-1:0];
      end
   end

   always_comb begin
      if (window_len_ff == '0) begin
         win_len = K_W'(1);
      end else if (32'(window_len_ff) > 32'(WINDOW_MAX)) begin
         win_len = K_W'(WINDOW_MAX);
      end else begin
         win_len = K_W'(window_len_ff);
      end
   end

   mwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mwa_datapath #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .cfg_restart         (csr_write),
      .win_len             (win_len),
      .req_sample          (req_sample),
      .req_end_of_sequence (req_end_of_sequence),
      .rsp_max_average     (rsp_max_average),
      .rsp_window_found    (rsp_window_found)
   );

endmodule
